// ===== hw/rtl/usm_pkg.sv =====
// ----------------------------------------------------------------------------
// usm_pkg: shared definitions for the ultrasonic range and speed meter
// Register indexes, report codes, field widths and the count-to-cm scale.
// ----------------------------------------------------------------------------
`default_nettype none

package usm_pkg;

	// echo counter width
	localparam int COUNT_WIDTH = 16;

	// field widths
	localparam int TRIG_WIDTH   = 8;
	localparam int GAP_WIDTH    = 16;
	localparam int HOLD_WIDTH   = 20;
	localparam int DIST_WIDTH   = 12;
	localparam int SPEED_WIDTH  = 14;
	localparam int REPORT_WIDTH = 2;
	localparam int TIMER_WIDTH  = 20;
	localparam int CFG_IDX_WIDTH  = 3;
	localparam int CFG_DATA_WIDTH = 20;

	// distance = floor(count * DIST_NUM / DIST_DEN) + 1, saturated
	localparam int DIST_NUM  = 100;
	localparam int DIST_DEN  = 2941;
	localparam int REM_WIDTH = $clog2(DIST_DEN + DIST_NUM);
	localparam int SPEED_FACTOR = 6;

	// register indexes
	localparam logic [CFG_IDX_WIDTH-1:0] REG_TRIGGER_TICKS = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_GAP_TICKS     = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_HOLD_TICKS    = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_DISTANCE  = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_DISTANCE  = 3'd4;

	// register reset values
	localparam logic [TRIG_WIDTH-1:0] TRIGGER_TICKS_RST = 8'd10;
	localparam logic [GAP_WIDTH-1:0]  GAP_TICKS_RST     = 16'd10000;
	localparam logic [HOLD_WIDTH-1:0] HOLD_TICKS_RST    = 20'd100000;
	localparam logic [DIST_WIDTH-1:0] MIN_DISTANCE_RST  = 12'd2;
	localparam logic [DIST_WIDTH-1:0] MAX_DISTANCE_RST  = 12'd400;

	// report codes
	localparam logic [REPORT_WIDTH-1:0] REPORT_NONE  = 2'd0;
	localparam logic [REPORT_WIDTH-1:0] REPORT_VALID = 2'd1;
	localparam logic [REPORT_WIDTH-1:0] REPORT_RANGE = 2'd2;
	localparam logic [REPORT_WIDTH-1:0] REPORT_AWAIT = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/ultrasonic_range_speed_meter.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_range_speed_meter: echo ranging controller with speed estimate
// Takes one timer tick per input transfer and gives one result per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one tick: echo_level and
//   button_level. Output channel (out_valid/out_ready) returns one result per
//   tick: trigger_level, report, distance_cm and speed.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   the five registers; it is always ready. Write only while idle.
//   The result of an accepted tick is registered and shows at the output in
//   the next cycle. Throughput is one tick per cycle while the receiver takes
//   results; the output register is refilled in the same cycle it is drained.
//   The distance is tracked as a running quotient and remainder that advance
//   by one add and compare per echo tick, so no divider is needed.
//   When the receiver stalls, the result holds in the output register and
//   in_ready drops until it is taken.
//   Reset puts the sequencer in idle, clears counters and loads the register
//   defaults; no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_range_speed_meter (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// configuration
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [usm_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
	input  wire logic [usm_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
	// tick input
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  echo_level,
	input  wire logic                                  button_level,
	// result output
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic                                       trigger_level,
	output logic [usm_pkg::REPORT_WIDTH-1:0]           report,
	output logic [usm_pkg::DIST_WIDTH-1:0]             distance_cm,
	output logic [usm_pkg::SPEED_WIDTH-1:0]            speed
);

	localparam int CW = usm_pkg::COUNT_WIDTH;
	localparam int DW = usm_pkg::DIST_WIDTH;
	localparam int TW = usm_pkg::TIMER_WIDTH;
	localparam int RW = usm_pkg::REM_WIDTH;
	localparam int SW = usm_pkg::SPEED_WIDTH;

	localparam logic [DW-1:0] QUOT_MAX  = {{(DW-1){1'b1}}, 1'b0};
	localparam logic [RW-1:0] REM_STEP  = RW'(usm_pkg::DIST_NUM);
	localparam logic [RW-1:0] REM_DEN   = RW'(usm_pkg::DIST_DEN);
	localparam logic [SW:0]   SPEED_SAT = {1'b0, {SW{1'b1}}};

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_TRIG_A = 4'd1,
		PH_WAIT_A = 4'd2,
		PH_CNT_A  = 4'd3,
		PH_GAP    = 4'd4,
		PH_TRIG_B = 4'd5,
		PH_WAIT_B = 4'd6,
		PH_CNT_B  = 4'd7,
		PH_HOLD   = 4'd8
	} phase_t;

	// configuration registers
	logic [usm_pkg::TRIG_WIDTH-1:0] trigger_ticks_q;
	logic [usm_pkg::GAP_WIDTH-1:0]  gap_ticks_q;
	logic [usm_pkg::HOLD_WIDTH-1:0] hold_ticks_q;
	logic [DW-1:0]                  min_distance_q;
	logic [DW-1:0]                  max_distance_q;

	// sequencer state
	phase_t        phase_q, phase_d;
	logic [TW-1:0] timer_q, timer_d;
	logic [CW-1:0] count_q, count_d;
	logic [DW-1:0] quot_q, quot_d;
	logic [RW-1:0] rem_q, rem_d;
	logic [DW-1:0] first_q, first_d;

	// next result
	logic                             trig_d;
	logic [usm_pkg::REPORT_WIDTH-1:0] report_d;
	logic [DW-1:0]                    dist_d;
	logic [SW-1:0]                    speed_d;

	logic          in_xfer;
	logic          go_idle;
	logic [RW-1:0] rem_sum;
	logic [DW-1:0] dist_now;
	logic [DW-1:0] diff;
	logic [SW:0]   speed_raw;
	logic          a_ok;
	logic          b_ok;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid || out_ready;
	assign in_xfer   = in_valid && in_ready;

	// quotient never passes QUOT_MAX, so the +1 cannot overflow
	assign dist_now  = quot_q + DW'(1);
	assign rem_sum   = rem_q + REM_STEP;
	assign diff      = (first_q > dist_now) ? (first_q - dist_now) : (dist_now - first_q);
	assign speed_raw = {1'b0, diff, 2'b00} + {2'b00, diff, 1'b0};
	assign a_ok      = (first_q >= min_distance_q) && (first_q <= max_distance_q);
	assign b_ok      = (dist_now >= min_distance_q) && (dist_now <= max_distance_q);

	always_comb begin
		phase_d  = phase_q;
		timer_d  = timer_q;
		count_d  = count_q;
		quot_d   = quot_q;
		rem_d    = rem_q;
		first_d  = first_q;
		trig_d   = 1'b0;
		report_d = usm_pkg::REPORT_NONE;
		dist_d   = '0;
		speed_d  = '0;
		go_idle  = 1'b0;

		case (phase_q)
			PH_HOLD: begin
				if (timer_q < hold_ticks_q) begin
					timer_d = timer_q + TW'(1);
				end else begin
					// hold ends: this tick checks the button
					go_idle = 1'b1;
				end
			end
			PH_TRIG_A, PH_TRIG_B: begin
				if (timer_q >= TW'(trigger_ticks_q)) begin
					phase_d = (phase_q == PH_TRIG_A) ? PH_WAIT_A : PH_WAIT_B;
					timer_d = '0;
				end else begin
					trig_d  = 1'b1;
					timer_d = timer_q + TW'(1);
				end
			end
			PH_WAIT_A, PH_WAIT_B: begin
				if (echo_level) begin
					count_d = CW'(1);
					quot_d  = '0;
					rem_d   = REM_STEP;
					phase_d = (phase_q == PH_WAIT_A) ? PH_CNT_A : PH_CNT_B;
				end
			end
			PH_CNT_A, PH_CNT_B: begin
				if (echo_level) begin
					count_d = count_q + CW'(1);
					if (count_q == {CW{1'b1}}) begin
						// counter wraps to zero
						quot_d = '0;
						rem_d  = '0;
					end else if (rem_sum >= REM_DEN) begin
						rem_d  = rem_sum - REM_DEN;
						quot_d = (quot_q == QUOT_MAX) ? quot_q : quot_q + DW'(1);
					end else begin
						rem_d = rem_sum;
					end
				end else if (phase_q == PH_CNT_A) begin
					first_d = dist_now;
					phase_d = PH_GAP;
					timer_d = '0;
				end else begin
					if (a_ok && b_ok) begin
						report_d = usm_pkg::REPORT_VALID;
						dist_d   = dist_now;
						speed_d  = (speed_raw > SPEED_SAT) ? SW'(SPEED_SAT) : SW'(speed_raw);
					end else begin
						report_d = usm_pkg::REPORT_RANGE;
					end
					phase_d = PH_HOLD;
					timer_d = '0;
				end
			end
			PH_GAP: begin
				if (timer_q >= TW'(gap_ticks_q)) begin
					trig_d  = 1'b1;
					count_d = '0;
					quot_d  = '0;
					rem_d   = '0;
					phase_d = PH_TRIG_B;
					timer_d = TW'(1);
				end else begin
					timer_d = timer_q + TW'(1);
				end
			end
			default: begin
				go_idle = 1'b1;
			end
		endcase

		if (go_idle) begin
			phase_d = PH_IDLE;
			if (button_level) begin
				trig_d  = 1'b1;
				count_d = '0;
				quot_d  = '0;
				rem_d   = '0;
				phase_d = PH_TRIG_A;
				timer_d = TW'(1);
			end else begin
				report_d = usm_pkg::REPORT_AWAIT;
				timer_d  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_ticks_q <= usm_pkg::TRIGGER_TICKS_RST;
			gap_ticks_q     <= usm_pkg::GAP_TICKS_RST;
			hold_ticks_q    <= usm_pkg::HOLD_TICKS_RST;
			min_distance_q  <= usm_pkg::MIN_DISTANCE_RST;
			max_distance_q  <= usm_pkg::MAX_DISTANCE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				usm_pkg::REG_TRIGGER_TICKS: begin
					trigger_ticks_q <= cfg_data[usm_pkg::TRIG_WIDTH-1:0];
				end
				usm_pkg::REG_GAP_TICKS: begin
					gap_ticks_q <= cfg_data[usm_pkg::GAP_WIDTH-1:0];
				end
				usm_pkg::REG_HOLD_TICKS: begin
					hold_ticks_q <= cfg_data[usm_pkg::HOLD_WIDTH-1:0];
				end
				usm_pkg::REG_MIN_DISTANCE: begin
					min_distance_q <= cfg_data[DW-1:0];
				end
				usm_pkg::REG_MAX_DISTANCE: begin
					max_distance_q <= cfg_data[DW-1:0];
				end
				default: begin
					// drop writes to unknown indexes
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			timer_q   <= '0;
			count_q   <= '0;
			quot_q    <= '0;
			rem_q     <= '0;
			first_q   <= '0;
			out_valid <= 1'b0;
		end else if (in_xfer) begin
			phase_q   <= phase_d;
			timer_q   <= timer_d;
			count_q   <= count_d;
			quot_q    <= quot_d;
			rem_q     <= rem_d;
			first_q   <= first_d;
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// result register: load on every input transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			trigger_level <= trig_d;
			report        <= report_d;
			distance_cm   <= dist_d;
			speed         <= speed_d;
		end
	end

endmodule

`default_nettype wire

// ===== bench/ultrasonic_range_speed_meter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ultrasonic_range_speed_meter_tb: self-checking bench for the range meter
// Feeds timer ticks planned as whole measurement sequences, mirrors the
// sequencer in a cycle-free predictor, and compares every returned result
// field by field. Register writes are slotted in only after the block drains.
// ----------------------------------------------------------------------------

module ultrasonic_range_speed_meter_tb;
	import usm_pkg::*;

	localparam int unsigned WATCHDOG_NS  = 20_000_000;
	localparam int          RANDOM_TICKS = 550;
	localparam int          TAIL_OPS     = 150;
	localparam int          DRAIN_CYCLES = 2;
	localparam int          END_CYCLES   = 8;
	localparam int          MAX_PRINTS   = 40;
	localparam int unsigned CM_NUM       = 100;
	localparam int unsigned CM_DEN       = 2941;
	localparam int unsigned CM_CAP       = (1 << DIST_WIDTH) - 1;
	localparam int unsigned SPEED_MUL    = 6;
	localparam int unsigned SPEED_CAP    = (1 << SPEED_WIDTH) - 1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE, ST_TRIG_A, ST_WAIT_A, ST_CNT_A, ST_GAP,
		ST_TRIG_B, ST_WAIT_B, ST_CNT_B, ST_HOLD
	} meter_phase_e;

	typedef struct {
		logic                      is_write;
		logic [CFG_IDX_WIDTH-1:0]  idx;
		logic [CFG_DATA_WIDTH-1:0] data;
		logic                      echo;
		logic                      button;
	} planned_op_t;

	typedef struct {
		logic                    trig;
		logic [REPORT_WIDTH-1:0] rep;
		logic [DIST_WIDTH-1:0]   dist_cm;
		logic [SPEED_WIDTH-1:0]  spd;
	} meter_result_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_WIDTH-1:0]  cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      echo_level = 1'b0;
	logic                      button_level = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      trigger_level;
	logic [REPORT_WIDTH-1:0]   report;
	logic [DIST_WIDTH-1:0]     distance_cm;
	logic [SPEED_WIDTH-1:0]    speed;

	ultrasonic_range_speed_meter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.echo_level   (echo_level),
		.button_level (button_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.trigger_level(trigger_level),
		.report       (report),
		.distance_cm  (distance_cm),
		.speed        (speed)
	);

	// stimulus plan and its view of the register settings
	planned_op_t           planned_ops[$];
	int                    planned_ticks = 0;
	logic [TRIG_WIDTH-1:0] plan_trig = 8'd10;
	logic [GAP_WIDTH-1:0]  plan_gap = 16'd10000;
	logic [HOLD_WIDTH-1:0] plan_hold = 20'd100000;

	// predictor registers and sequencer state
	logic [TRIG_WIDTH-1:0]  set_trig = 8'd10;
	logic [GAP_WIDTH-1:0]   set_gap = 16'd10000;
	logic [HOLD_WIDTH-1:0]  set_hold = 20'd100000;
	logic [DIST_WIDTH-1:0]  set_min = 12'd2;
	logic [DIST_WIDTH-1:0]  set_max = 12'd400;
	meter_phase_e           seq_st = ST_IDLE;
	logic [TIMER_WIDTH-1:0] seq_tmr = '0;
	logic [COUNT_WIDTH-1:0] seq_cnt = '0;
	logic [DIST_WIDTH-1:0]  seq_first_cm = '0;

	meter_result_t predicted_outputs[$];
	int            ticks_taken = 0;
	int            results_seen = 0;
	int            mismatches = 0;
	logic          tail_quiet = 1'b0;
	int            send_gap = 0;
	int            send_calm = 0;
	int            settle = 0;
	int            recv_gap = 0;
	int            recv_calm = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(WATCHDOG_NS);
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic logic [DIST_WIDTH-1:0] echo_to_cm(input logic [COUNT_WIDTH-1:0] count);
		longint unsigned cm;
		cm = count;
		cm = cm * CM_NUM / CM_DEN + 1;
		return (cm > CM_CAP) ? DIST_WIDTH'(CM_CAP) : DIST_WIDTH'(cm);
	endfunction

	function automatic void load_register(input logic [CFG_IDX_WIDTH-1:0] idx,
			input logic [CFG_DATA_WIDTH-1:0] data);
		case (idx)
			REG_TRIGGER_TICKS: set_trig = data[TRIG_WIDTH-1:0];
			REG_GAP_TICKS:     set_gap = data[GAP_WIDTH-1:0];
			REG_HOLD_TICKS:    set_hold = data[HOLD_WIDTH-1:0];
			REG_MIN_DISTANCE:  set_min = data[DIST_WIDTH-1:0];
			REG_MAX_DISTANCE:  set_max = data[DIST_WIDTH-1:0];
			default: ;
		endcase
	endfunction

	task automatic advance_meter(input logic echo, input logic button, output meter_result_t res);
		int unsigned cm_a, cm_b, diff, spd;
		res.trig    = 1'b0;
		res.rep     = REPORT_NONE;
		res.dist_cm = '0;
		res.spd     = '0;
		// the tick that ends the hold is handled as an idle tick
		if (seq_st == ST_HOLD) begin
			if (seq_tmr < set_hold)
				seq_tmr = seq_tmr + 1'b1;
			else
				seq_st = ST_IDLE;
		end
		case (seq_st)
			ST_HOLD: ;
			ST_TRIG_A, ST_TRIG_B: begin
				if (seq_tmr >= set_trig) begin
					seq_st  = (seq_st == ST_TRIG_A) ? ST_WAIT_A : ST_WAIT_B;
					seq_tmr = '0;
				end else begin
					res.trig = 1'b1;
					seq_tmr  = seq_tmr + 1'b1;
				end
			end
			ST_WAIT_A, ST_WAIT_B: begin
				if (echo) begin
					seq_cnt = COUNT_WIDTH'(1);
					seq_st  = (seq_st == ST_WAIT_A) ? ST_CNT_A : ST_CNT_B;
				end
			end
			ST_CNT_A: begin
				if (echo) begin
					seq_cnt = seq_cnt + 1'b1;
				end else begin
					seq_first_cm = echo_to_cm(seq_cnt);
					seq_st       = ST_GAP;
					seq_tmr      = '0;
				end
			end
			ST_GAP: begin
				if (seq_tmr >= set_gap) begin
					res.trig = 1'b1;
					seq_cnt  = '0;
					seq_st   = ST_TRIG_B;
					seq_tmr  = TIMER_WIDTH'(1);
				end else begin
					seq_tmr = seq_tmr + 1'b1;
				end
			end
			ST_CNT_B: begin
				if (echo) begin
					seq_cnt = seq_cnt + 1'b1;
				end else begin
					cm_a = 32'(seq_first_cm);
					cm_b = 32'(echo_to_cm(seq_cnt));
					diff = (cm_a > cm_b) ? cm_a - cm_b : cm_b - cm_a;
					spd  = diff * SPEED_MUL;
					if (spd > SPEED_CAP)
						spd = SPEED_CAP;
					if (cm_a >= set_min && cm_a <= set_max && cm_b >= set_min && cm_b <= set_max) begin
						res.rep     = REPORT_VALID;
						res.dist_cm = DIST_WIDTH'(cm_b);
						res.spd     = SPEED_WIDTH'(spd);
					end else begin
						res.rep = REPORT_RANGE;
					end
					seq_st  = ST_HOLD;
					seq_tmr = '0;
				end
			end
			default: begin
				seq_st = ST_IDLE;
				if (button) begin
					res.trig = 1'b1;
					seq_cnt  = '0;
					seq_st   = ST_TRIG_A;
					seq_tmr  = TIMER_WIDTH'(1);
				end else begin
					res.rep = REPORT_AWAIT;
					seq_tmr = '0;
				end
			end
		endcase
	endtask

	task automatic push_tick(input logic echo, input logic button);
		planned_op_t op;
		op.is_write = 1'b0;
		op.idx      = '0;
		op.data     = '0;
		op.echo     = echo;
		op.button   = button;
		planned_ops.push_back(op);
		planned_ticks++;
	endtask

	task automatic push_write(input logic [CFG_IDX_WIDTH-1:0] idx,
			input logic [CFG_DATA_WIDTH-1:0] data);
		planned_op_t op;
		op.is_write = 1'b1;
		op.idx      = idx;
		op.data     = data;
		op.echo     = 1'b0;
		op.button   = 1'b0;
		planned_ops.push_back(op);
		case (idx)
			REG_TRIGGER_TICKS: plan_trig = data[TRIG_WIDTH-1:0];
			REG_GAP_TICKS:     plan_gap = data[GAP_WIDTH-1:0];
			REG_HOLD_TICKS:    plan_hold = data[HOLD_WIDTH-1:0];
			default: ;
		endcase
	endtask

	task automatic plan_echo(input int high_ticks, input int wait_ticks);
		repeat (wait_ticks) push_tick(1'b0, coin());
		repeat (high_ticks) push_tick(1'b1, coin());
		push_tick(1'b0, coin());
	endtask

	// one press through the end of the hold; ignored ticks carry random levels
	task automatic plan_measurement(input int high_a, input int high_b, input int wait_a,
			input int wait_b);
		int trig_len;
		trig_len = (plan_trig == 0) ? 1 : int'(plan_trig);
		push_tick(coin(), 1'b1);
		repeat (trig_len) push_tick(coin(), coin());
		plan_echo(high_a, wait_a);
		repeat (int'(plan_gap) + 1) push_tick(coin(), coin());
		repeat (trig_len) push_tick(coin(), coin());
		plan_echo(high_b, wait_b);
		repeat (plan_hold) push_tick(coin(), coin());
	endtask

	function automatic int echo_span();
		case ($urandom_range(0, 7))
			0: return $urandom_range(1, 3);
			// straddle the first centimeter steps
			1: return 29 + $urandom_range(0, 1) + 29 * $urandom_range(0, 1);
			default: return $urandom_range(1, 150);
		endcase
	endfunction

	function automatic int wait_span();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
	endfunction

	task automatic plan_random_segment();
		logic wide;
		int   runs;
		wide = ($urandom_range(0, 7) == 0);
		// upper data bits are junk the register must drop
		push_write(REG_TRIGGER_TICKS,
			(20'($urandom) & 20'hFFF00) | 20'($urandom_range(0, wide ? 40 : 6)));
		push_write(REG_GAP_TICKS,
			(20'($urandom) & 20'hF0000) | 20'($urandom_range(0, wide ? 60 : 8)));
		push_write(REG_HOLD_TICKS, 20'($urandom_range(0, wide ? 60 : 8)));
		push_write(REG_MIN_DISTANCE,
			(20'($urandom) & 20'hFF000) | 20'($urandom_range(0, 5)));
		push_write(REG_MAX_DISTANCE,
			(20'($urandom) & 20'hFF000) | 20'($urandom_range(0, 8)));
		runs = $urandom_range(1, 4);
		repeat (runs) begin
			repeat ($urandom_range(0, 3)) push_tick(coin(), 1'b0);
			plan_measurement(echo_span(), echo_span(), wait_span(), wait_span());
		end
		repeat ($urandom_range(1, 3)) push_tick(coin(), 1'b0);
	endtask

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			if (mismatches < MAX_PRINTS)
				$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive_ticks
		planned_op_t   op;
		meter_result_t want;
		logic          next_in, next_cfg;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				advance_meter(echo_level, button_level, want);
				predicted_outputs.push_back(want);
				ticks_taken++;
			end
			if (cfg_valid && cfg_ready)
				load_register(cfg_index, cfg_data);
			next_in  = in_valid && !in_ready;
			next_cfg = cfg_valid && !cfg_ready;
			if (!next_in && !next_cfg) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (planned_ops.size() != 0) begin
					if (planned_ops[0].is_write) begin
						// hold the write until every result has drained
						settle = (ticks_taken == results_seen) ? settle + 1 : 0;
						if (settle > DRAIN_CYCLES) begin
							op = planned_ops.pop_front();
							cfg_index <= op.idx;
							cfg_data  <= op.data;
							next_cfg = 1'b1;
							settle   = 0;
						end
					end else if (!tail_quiet && send_calm == 0 && $urandom_range(0, 5) == 0) begin
						send_gap = $urandom_range(0, 2);
					end else begin
						op = planned_ops.pop_front();
						echo_level   <= op.echo;
						button_level <= op.button;
						next_in = 1'b1;
						if (send_calm > 0)
							send_calm--;
						else if ($urandom_range(0, 39) == 0)
							send_calm = $urandom_range(20, 80);
					end
				end
			end
			in_valid   <= next_in;
			cfg_valid  <= next_cfg;
			tail_quiet <= (planned_ops.size() < TAIL_OPS);
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch_results
		meter_result_t want;
		logic          next_ready;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_outputs.size() == 0) begin
					if (mismatches < MAX_PRINTS)
						$display("%0t ns: result with none pending, expected none, actual %0d/%0d/%0d/%0d",
							$time, trigger_level, report, distance_cm, speed);
					mismatches++;
				end else begin
					want = predicted_outputs.pop_front();
					check_field("trigger_level", 16'(want.trig), 16'(trigger_level));
					check_field("report", 16'(want.rep), 16'(report));
					check_field("distance_cm", 16'(want.dist_cm), 16'(distance_cm));
					check_field("speed", 16'(want.spd), 16'(speed));
				end
				results_seen <= results_seen + 1;
			end
			if (tail_quiet) begin
				next_ready = 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				next_ready = 1'b0;
			end else if (recv_calm == 0 && $urandom_range(0, 6) == 0) begin
				recv_gap   = $urandom_range(0, 2);
				next_ready = 1'b0;
			end else begin
				next_ready = 1'b1;
				if (recv_calm > 0)
					recv_calm--;
				else if ($urandom_range(0, 39) == 0)
					recv_calm = $urandom_range(20, 80);
			end
			out_ready <= next_ready;
		end
	end

	initial begin : run_plan
		int rand_start;

		// defaults except a short gap and hold; a few idle ticks first
		push_write(REG_HOLD_TICKS, 20'd3);
		push_write(REG_GAP_TICKS, 20'd12);
		repeat (4) push_tick(coin(), 1'b0);
		plan_measurement(40, 90, 3, 0);
		push_tick(coin(), 1'b0);

		// zero trigger, gap and hold, widest window; junk in the upper data bits
		push_write(REG_TRIGGER_TICKS, 20'hFFF00);
		push_write(REG_GAP_TICKS, 20'hF0000);
		push_write(REG_HOLD_TICKS, 20'd0);
		push_write(REG_MIN_DISTANCE, 20'hFF000);
		push_write(REG_MAX_DISTANCE, 20'd4095);
		plan_measurement(1, 1, 0, 0);
		plan_measurement(150, 1, 2, 1);
		push_tick(coin(), 1'b0);

		// longer trigger and gap, minimum above maximum
		push_write(REG_TRIGGER_TICKS, 20'd60);
		push_write(REG_GAP_TICKS, 20'd80);
		push_write(REG_HOLD_TICKS, 20'd1);
		push_write(REG_MIN_DISTANCE, 20'd10);
		push_write(REG_MAX_DISTANCE, 20'd5);
		plan_measurement(30, 45, 1, 1);
		push_tick(coin(), 1'b0);

		// longest hold and extreme window with the button left released
		push_write(REG_HOLD_TICKS, 20'hFFFFF);
		push_write(REG_MIN_DISTANCE, 20'd4095);
		push_write(REG_MAX_DISTANCE, 20'd0);
		push_write(REG_SPARE, 20'h5A5A5);
		repeat (8) push_tick(coin(), 1'b0);

		rand_start = planned_ticks;
		while (planned_ticks - rand_start < RANDOM_TICKS)
			plan_random_segment();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (planned_ops.size() != 0 || in_valid || cfg_valid || ticks_taken != results_seen);
		repeat (END_CYCLES) @(posedge clk);

		if (mismatches == 0 && predicted_outputs.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
